@@ rtl/carv_pkg.sv @@
// ----------------------------------------------------------------------------
// carv_pkg: shared types and constants
// Filter lengths and offsets, sequencer states, configuration indices and saturation.
// ----------------------------------------------------------------------------
package carv_pkg;

  localparam int NCOMB = 8;
  localparam int NAP = 4;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PD_RD,
    ST_PD_WAIT,
    ST_COMB_RD,
    ST_COMB_WAIT,
    ST_COMB_DAMP,
    ST_COMB_FB,
    ST_COMB_WR,
    ST_AP_RD,
    ST_AP_WAIT,
    ST_AP_WR,
    ST_WET,
    ST_MIX,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    CFG_FEEDBACK = 3'd0,
    CFG_DAMPING  = 3'd1,
    CFG_WET      = 3'd2,
    CFG_ROOM     = 3'd3,
    CFG_PREDELAY = 3'd4,
    CFG_DRY_MUTE = 3'd5
  } cfg_idx_t;

  function automatic logic [10:0] comb_base(input logic [2:0] i);
    logic [10:0] r;
    case (i)
      3'd0: r = 11'd1116;
      3'd1: r = 11'd1188;
      3'd2: r = 11'd1277;
      3'd3: r = 11'd1356;
      3'd4: r = 11'd1422;
      3'd5: r = 11'd1491;
      3'd6: r = 11'd1557;
      default: r = 11'd1617;
    endcase
    return r;
  endfunction

  function automatic logic [13:0] comb_off(input logic [2:0] i);
    logic [13:0] r;
    case (i)
      3'd0: r = 14'd0;
      3'd1: r = 14'd1116;
      3'd2: r = 14'd2304;
      3'd3: r = 14'd3581;
      3'd4: r = 14'd4937;
      3'd5: r = 14'd6359;
      3'd6: r = 14'd7850;
      default: r = 14'd9407;
    endcase
    return r;
  endfunction

  function automatic logic [9:0] ap_len(input logic [1:0] i);
    logic [9:0] r;
    case (i)
      2'd0: r = 10'd225;
      2'd1: r = 10'd341;
      2'd2: r = 10'd441;
      default: r = 10'd556;
    endcase
    return r;
  endfunction

  function automatic logic [10:0] ap_off(input logic [1:0] i);
    logic [10:0] r;
    case (i)
      2'd0: r = 11'd0;
      2'd1: r = 11'd225;
      2'd2: r = 11'd566;
      default: r = 11'd1007;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    logic signed [31:0] r;
    if (x > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -34'sh0_8000_0000) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32_wide(input logic signed [34:0] x);
    logic signed [31:0] r;
    if (x > 35'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -35'sh0_8000_0000) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

@@ rtl/carv_mac.sv @@
// ----------------------------------------------------------------------------
// carv_mac: shared multiplier
// One registered product of a signed 34-bit and an unsigned 17-bit operand, rounded and shifted downstream.
// ----------------------------------------------------------------------------
module carv_mac (
  input  logic               clk,
  input  logic signed [33:0] a,
  input  logic        [16:0] b,
  output logic signed [51:0] p
);

  always_ff @(posedge clk) begin
    p <= a * $signed({1'b0, b});
  end

endmodule

@@ rtl/comb_allpass_reverb.sv @@
// ----------------------------------------------------------------------------
// comb_allpass_reverb: mono comb/allpass reverb
// Pre-delay, eight damped combs, four allpasses, wet scale and dry mix.
// ----------------------------------------------------------------------------
// out_valid rises once an accepted sample has passed the pre-delay read
// (PD_RD, PD_WAIT), the eight combs in turn around the single shared
// multiplier and comb memory port (COMB_RD, COMB_WAIT, COMB_DAMP, COMB_FB,
// COMB_WR each), the four allpasses on the allpass memory (AP_RD, AP_WAIT,
// AP_WR each), then the wet product and the mix. No new sample is taken until
// the result leaves ST_OUT. Reset and every write of the room size or
// predelay_samples clear all three memories; no sample is accepted meanwhile.
module comb_allpass_reverb #(
  parameter int COMB_STORE     = 16384,
  parameter int ALLPASS_STORE  = 2048,
  parameter int PREDELAY_DEPTH = 32768,
  parameter int SAMPLE_BITS    = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [16:0]                   cfg_data
);

  localparam int CW = $clog2(COMB_STORE);
  localparam int AW = $clog2(ALLPASS_STORE);
  localparam int PW = (PREDELAY_DEPTH > 1) ? $clog2(PREDELAY_DEPTH) : 1;
  localparam int MAXD = (COMB_STORE > PREDELAY_DEPTH) ? COMB_STORE : PREDELAY_DEPTH;
  localparam int MAXA = (MAXD > ALLPASS_STORE) ? MAXD : ALLPASS_STORE;
  localparam int XW = $clog2(MAXA + 1);
  localparam logic [PW-1:0] PD_LAST = PW'(PREDELAY_DEPTH - 1);
  localparam logic signed [SAMPLE_BITS:0] SMAX = (SAMPLE_BITS+1)'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
  localparam logic signed [SAMPLE_BITS:0] SMIN = -SMAX - 1;

  carv_pkg::state_t state, state_next;

  logic [15:0] feedback_gain, damping, wet_level;
  logic [16:0] room_size;
  logic [14:0] predelay_samples;
  logic        dry_mute;

  logic signed [31:0] comb_mem [COMB_STORE];
  logic signed [31:0] ap_mem [ALLPASS_STORE];
  logic signed [SAMPLE_BITS-1:0] pd_mem [PREDELAY_DEPTH];

  logic [13:0] comb_ptr [carv_pkg::NCOMB];
  logic [10:0] comb_len [carv_pkg::NCOMB];
  logic signed [31:0] damp_st [carv_pkg::NCOMB];
  logic [9:0]  ap_ptr [carv_pkg::NAP];
  logic [PW-1:0] pd_ptr;

  logic [XW-1:0] clr_cnt;
  logic [2:0]  ci;
  logic [1:0]  ai;
  logic signed [SAMPLE_BITS-1:0] dry;
  logic signed [31:0] val, acc, tap, st;
  logic signed [34:0] comb_sum;
  logic signed [31:0] comb_rd, ap_rd;
  logic signed [SAMPLE_BITS-1:0] pd_rd;
  logic [CW-1:0] comb_addr;
  logic [AW-1:0] ap_addr;

  logic signed [33:0] mul_a;
  logic [16:0] mul_b;
  logic signed [51:0] prod;
  logic clear_req;

  carv_mac u_mac (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  // rounded product terms
  logic signed [51:0] r16, r20;
  assign r16 = (prod + 52'sd32768) >>> 16;
  assign r20 = (prod + 52'sd524288) >>> 20;

  // comb lengths: base length times room size, rounded, at least one
  logic [16:0] rs_sat;
  assign rs_sat = (room_size > 17'd65536) ? 17'd65536 : room_size;

  always_ff @(posedge clk) begin
    for (int i = 0; i < carv_pkg::NCOMB; i++) begin
      logic [27:0] t;
      t = 28'(carv_pkg::comb_base(3'(i))) * 28'(rs_sat) + 28'd32768;
      comb_len[i] <= (t[27:16] == 12'd0) ? 11'd1 : t[26:16];
    end
  end

  logic [CW-1:0] caddr_calc;
  logic [14:0] craw;
  assign craw = 15'(carv_pkg::comb_off(ci)) + 15'(comb_ptr[ci]);
  assign caddr_calc = (32'(craw) >= COMB_STORE) ? '0 : CW'(craw);
  logic [CW-1:0] comb_addr_next;
  assign comb_addr_next = (comb_ptr[ci] >= 14'(comb_len[ci]))
                          ? ((32'(carv_pkg::comb_off(ci)) >= COMB_STORE) ? '0
                             : CW'(carv_pkg::comb_off(ci)))
                          : caddr_calc;
  logic [AW-1:0] aaddr_calc;
  logic [11:0] araw;
  assign araw = 12'(carv_pkg::ap_off(ai)) + 12'(ap_ptr[ai]);
  assign aaddr_calc = (32'(araw) >= ALLPASS_STORE) ? '0 : AW'(araw);

  logic [PW-1:0] pd_d, pd_rp;
  assign pd_d = (32'(predelay_samples) > 32'(PREDELAY_DEPTH - 1)) ? PD_LAST : PW'(predelay_samples);
  assign pd_rp = (pd_ptr >= pd_d) ? pd_ptr - pd_d : PW'(32'(pd_ptr) + PREDELAY_DEPTH - 32'(pd_d));

  assign clear_req = cfg_we && (cfg_index == carv_pkg::CFG_ROOM || cfg_index == carv_pkg::CFG_PREDELAY);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      feedback_gain <= 16'd57782;
      damping <= 16'd22938;
      wet_level <= 16'd15729;
      room_size <= 17'd65536;
      predelay_samples <= '0;
      dry_mute <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        carv_pkg::CFG_FEEDBACK: feedback_gain <= cfg_data[15:0];
        carv_pkg::CFG_DAMPING:  damping <= cfg_data[15:0];
        carv_pkg::CFG_WET:      wet_level <= cfg_data[15:0];
        carv_pkg::CFG_ROOM:     room_size <= cfg_data;
        carv_pkg::CFG_PREDELAY: predelay_samples <= cfg_data[14:0];
        carv_pkg::CFG_DRY_MUTE: dry_mute <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      carv_pkg::ST_CLEAR:     if (32'(clr_cnt) >= MAXA - 1) state_next = carv_pkg::ST_IDLE;
      carv_pkg::ST_IDLE:      if (in_valid) state_next = carv_pkg::ST_PD_RD;
      carv_pkg::ST_PD_RD:     state_next = carv_pkg::ST_PD_WAIT;
      carv_pkg::ST_PD_WAIT:   state_next = carv_pkg::ST_COMB_RD;
      carv_pkg::ST_COMB_RD:   state_next = carv_pkg::ST_COMB_WAIT;
      carv_pkg::ST_COMB_WAIT: state_next = carv_pkg::ST_COMB_DAMP;
      carv_pkg::ST_COMB_DAMP: state_next = carv_pkg::ST_COMB_FB;
      carv_pkg::ST_COMB_FB:   state_next = carv_pkg::ST_COMB_WR;
      carv_pkg::ST_COMB_WR:   state_next = (ci == 3'd7) ? carv_pkg::ST_AP_RD : carv_pkg::ST_COMB_RD;
      carv_pkg::ST_AP_RD:     state_next = carv_pkg::ST_AP_WAIT;
      carv_pkg::ST_AP_WAIT:   state_next = carv_pkg::ST_AP_WR;
      carv_pkg::ST_AP_WR:     state_next = (ai == 2'd0) ? carv_pkg::ST_WET : carv_pkg::ST_AP_RD;
      carv_pkg::ST_WET:       state_next = carv_pkg::ST_MIX;
      carv_pkg::ST_MIX:       state_next = carv_pkg::ST_OUT;
      carv_pkg::ST_OUT:       if (out_ready) state_next = carv_pkg::ST_IDLE;
      default:                state_next = carv_pkg::ST_IDLE;
    endcase
    if (clear_req) state_next = carv_pkg::ST_CLEAR;
  end

  // outputs
  always_comb begin
    in_ready = (state == carv_pkg::ST_IDLE);
    out_valid = (state == carv_pkg::ST_OUT);
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      carv_pkg::ST_COMB_WAIT: begin
        mul_a = 34'(damp_st[ci]) - 34'(comb_rd);
        mul_b = {1'b0, damping};
      end
      carv_pkg::ST_COMB_FB: begin
        mul_a = 34'(st);
        mul_b = {1'b0, feedback_gain};
      end
      carv_pkg::ST_WET: begin
        mul_a = 34'(acc);
        mul_b = {1'b0, wet_level};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= carv_pkg::ST_CLEAR;
    else state <= state_next;
  end

  // memories
  always_ff @(posedge clk) begin
    comb_rd <= comb_mem[comb_addr_next];
    ap_rd <= ap_mem[ap_addr];
    pd_rd <= pd_mem[pd_rp];
    if (state == carv_pkg::ST_CLEAR) begin
      if (32'(clr_cnt) < COMB_STORE) comb_mem[CW'(clr_cnt)] <= '0;
      if (32'(clr_cnt) < ALLPASS_STORE) ap_mem[AW'(clr_cnt)] <= '0;
      if (32'(clr_cnt) < PREDELAY_DEPTH) pd_mem[PW'(clr_cnt)] <= '0;
    end else begin
      if (state == carv_pkg::ST_IDLE && in_valid) pd_mem[pd_ptr] <= sample_in;
      if (state == carv_pkg::ST_COMB_WR)
        comb_mem[comb_addr] <= carv_pkg::sat32(34'(val) + 34'(r16));
      if (state == carv_pkg::ST_AP_WR)
        ap_mem[ap_addr] <= carv_pkg::sat32(34'(acc) + ((34'(ap_rd) + 34'sd1) >>> 1));
    end
  end

  // datapath and pointers
  always_ff @(posedge clk) begin
    if (rst || clear_req) begin
      clr_cnt <= '0;
      pd_ptr <= '0;
      for (int i = 0; i < carv_pkg::NCOMB; i++) begin
        comb_ptr[i] <= '0;
        damp_st[i] <= '0;
      end
      for (int i = 0; i < carv_pkg::NAP; i++) ap_ptr[i] <= '0;
    end else begin
      unique case (state)
        carv_pkg::ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        carv_pkg::ST_IDLE: if (in_valid) begin
          dry <= sample_in;
          ci <= '0;
          comb_sum <= '0;
        end
        carv_pkg::ST_PD_RD: pd_ptr <= (pd_ptr == PD_LAST) ? '0 : pd_ptr + 1'b1;
        carv_pkg::ST_PD_WAIT: val <= 32'(pd_rd);
        carv_pkg::ST_COMB_RD: begin
          if (comb_ptr[ci] >= 14'(comb_len[ci])) comb_ptr[ci] <= '0;
          comb_addr <= comb_addr_next;
        end
        carv_pkg::ST_COMB_WAIT: tap <= comb_rd;
        carv_pkg::ST_COMB_DAMP: st <= carv_pkg::sat32(34'(tap) + 34'(r16));
        carv_pkg::ST_COMB_FB: begin
          damp_st[ci] <= st;
          comb_sum <= comb_sum + 35'(tap);
        end
        carv_pkg::ST_COMB_WR: begin
          comb_ptr[ci] <= (comb_ptr[ci] + 1'b1 >= 14'(comb_len[ci])) ? '0 : comb_ptr[ci] + 1'b1;
          ci <= ci + 1'b1;
          if (ci == 3'd7) begin
            acc <= carv_pkg::sat32_wide(comb_sum);
            ai <= 2'd3;
          end
        end
        carv_pkg::ST_AP_RD: ap_addr <= aaddr_calc;
        carv_pkg::ST_AP_WR: begin
          ap_ptr[ai] <= (ap_ptr[ai] + 1'b1 >= carv_pkg::ap_len(ai)) ? '0 : ap_ptr[ai] + 1'b1;
          acc <= carv_pkg::sat32(34'(ap_rd) - 34'(acc));
          ai <= ai - 1'b1;
        end
        carv_pkg::ST_OUT: ;
        default: ;
      endcase
    end
  end

  logic signed [SAMPLE_BITS:0] total;
  logic signed [52:0] tot_w;
  always_comb begin
    tot_w = 53'(r20) + (dry_mute ? 53'sd0 : 53'(dry));
    if (tot_w > 53'(SMAX)) total = SMAX;
    else if (tot_w < 53'(SMIN)) total = SMIN;
    else total = (SAMPLE_BITS+1)'(tot_w);
  end

  always_ff @(posedge clk) begin
    if (state == carv_pkg::ST_MIX) sample_out <= total[SAMPLE_BITS-1:0];
  end

endmodule

@@ rtl/carv_checker.sv @@
// ----------------------------------------------------------------------------
// carv_checker: port-level checks
// Handshake and sequencing properties seen at the top-level ports.
// ----------------------------------------------------------------------------
module carv_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_we
);

  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !cfg_we |=> out_valid)
    else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted twice");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind comb_allpass_reverb carv_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .cfg_we(cfg_we)
);
